FILE: rtl/core/sbc_pkg.sv
package sbc_pkg;

    localparam int KEY_W     = 64;
    localparam int CNT_W     = 32;
    localparam int PFX_W     = 4;
    localparam int KIND_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int KEY_BYTES = KEY_W / BYTE_W;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLASSIFY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SEARCH,
        ST_COUNT,
        ST_DONE
    } state_t;

    // per-cell controls from the sequencer
    typedef struct packed {
        logic wr;
        logic inc_even;
        logic inc_odd;
        logic clr;
    } cell_ctl_t;

    // per-cell registered compare results
    typedef struct packed {
        logic             le;
        logic             eq;
        logic [PFX_W-1:0] pfx;
    } cell_stat_t;

    // equal leading bytes, most significant byte first
    function automatic logic [PFX_W-1:0] lead_bytes(
        input logic [KEY_W-1:0] a,
        input logic [KEY_W-1:0] b
    );
        logic [KEY_W-1:0] diff;
        logic [PFX_W-1:0] n;
        logic             hit;
        diff = a ^ b;
        n    = '0;
        hit  = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (!hit && (diff[KEY_W-1-BYTE_W*i -: BYTE_W] == '0))
            begin
                n = n + 1'b1;
            end
            else
            begin
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    // saturating count increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

endpackage

FILE: rtl/core/sbc_cell.sv
module sbc_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sbc_pkg::KEY_W-1:0]     key,
    input  logic [sbc_pkg::KEY_W-1:0]     left_split,
    input  sbc_pkg::cell_ctl_t            ctl,
    output logic [sbc_pkg::KEY_W-1:0]     split,
    output sbc_pkg::cell_stat_t           stat,
    output logic [sbc_pkg::CNT_W-1:0]     cnt_even,
    output logic [sbc_pkg::CNT_W-1:0]     cnt_odd
);
    import sbc_pkg::*;

    logic [KEY_W-1:0] split_reg;
    cell_stat_t       stat_reg;
    cell_stat_t       stat_next;
    logic [CNT_W-1:0] even_reg;
    logic [CNT_W-1:0] even_next;
    logic [CNT_W-1:0] odd_reg;
    logic [CNT_W-1:0] odd_next;

    // compare against own splitter; prefix against the left neighbor's
    always_comb
    begin
        stat_next.le  = (key <= split_reg);
        stat_next.eq  = (key == split_reg);
        stat_next.pfx = lead_bytes(left_split, key);
    end

    always_comb
    begin
        even_next = even_reg;
        odd_next  = odd_reg;
        if (ctl.clr)
        begin
            even_next = '0;
            odd_next  = '0;
        end
        else
        begin
            if (ctl.inc_even)
            begin
                even_next = sat_inc(even_reg);
            end
            if (ctl.inc_odd)
            begin
                odd_next = sat_inc(odd_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            split_reg <= key;
        end
        stat_reg <= stat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            even_reg <= '0;
            odd_reg  <= '0;
        end
        else
        begin
            even_reg <= even_next;
            odd_reg  <= odd_next;
        end
    end

    assign split    = split_reg;
    assign stat     = stat_reg;
    assign cnt_even = even_reg;
    assign cnt_odd  = odd_reg;

endmodule

FILE: rtl/core/splitter_bucket_classifier_core.sv
// Splitter bucket classifier: counting pass of a string sample sort.
// Input channel in_valid/in_ready carries one request: kind, slot, key.
//   Load writes the splitter at slot and answers with the leading bytes it
//   shares with the slot below. Classify searches the splitters in use
//   (lower bound), bumps the bucket count, and answers bucket and count.
//   Clear zeroes every bucket count.
// Output channel out_valid/out_ready carries one response per request.
// Configuration: cfg_wr_en/cfg_wr_data write splitters_in_use at once.
// Steps: load, clear and unknown kinds pass through eval and done; classify
//   adds search, one binary search step per cycle over the cells' compare
//   bits, and count before done.
// One request in flight; the next is taken once the block is back in idle
//   after the response is registered.
// Reset clears all bucket counts and sets splitters_in_use to the table
//   size; splitter contents are undefined until loaded.
// A stalled receiver holds the response in the output register; the next
//   request is still taken and worked on, and waits at its end for the
//   output register to free.
module splitter_bucket_classifier_core #(
    parameter int MAX_SPLITTERS = 32
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_wr_en,
    input  logic [$clog2(MAX_SPLITTERS+1)-1:0]         cfg_wr_data,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic [sbc_pkg::KIND_W-1:0]                 kind,
    input  logic [$clog2(MAX_SPLITTERS)-1:0]           slot,
    input  logic [sbc_pkg::KEY_W-1:0]                  key,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [$clog2(2*MAX_SPLITTERS+2)-1:0]       bucket,
    output logic [sbc_pkg::CNT_W-1:0]                  bucket_count,
    output logic [sbc_pkg::PFX_W-1:0]                  common_prefix_bytes
);
    import sbc_pkg::*;

    localparam int SLOT_W = $clog2(MAX_SPLITTERS);
    localparam int USE_W  = $clog2(MAX_SPLITTERS + 1);
    localparam int BKT_W  = USE_W + 1;
    localparam logic [USE_W-1:0] N_U = USE_W'(MAX_SPLITTERS);

    state_t                 state_reg;
    state_t                 state_next;
    logic [KIND_W-1:0]      kind_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [USE_W-1:0]       in_use_reg;
    logic [USE_W-1:0]       lo_reg;
    logic [USE_W-1:0]       lo_next;
    logic [USE_W-1:0]       hi_reg;
    logic [USE_W-1:0]       hi_next;
    logic [BKT_W-1:0]       bucket_reg;
    logic [BKT_W-1:0]       bucket_next;
    logic [CNT_W-1:0]       tail_reg;
    logic [CNT_W-1:0]       tail_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [BKT_W-1:0]       bucket_out_reg;
    logic [CNT_W-1:0]       count_out_reg;
    logic [PFX_W-1:0]       pfx_out_reg;

    logic                   accept;
    logic                   out_free;
    logic                   out_load;
    logic [USE_W-1:0]       limit;
    logic [USE_W:0]         mid_sum;
    logic [USE_W-1:0]       mid;
    logic [USE_W-1:0]       pair;
    logic                   slot_ok;
    logic [BKT_W-1:0]       bucket_data;
    logic [CNT_W-1:0]       count_data;
    logic [PFX_W-1:0]       pfx_data;
    logic [CNT_W-1:0]       sel_count;

    logic [KEY_W-1:0]       split_vec [MAX_SPLITTERS];
    cell_stat_t             stat_vec  [MAX_SPLITTERS];
    cell_ctl_t              ctl_vec   [MAX_SPLITTERS];
    logic [CNT_W-1:0]       even_vec  [MAX_SPLITTERS];
    logic [CNT_W-1:0]       odd_vec   [MAX_SPLITTERS];

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // saturate the register to the table size
    assign limit   = (in_use_reg > N_U) ? N_U : in_use_reg;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[USE_W:1];
    assign pair    = bucket_reg[BKT_W-1:1];
    assign slot_ok = ({{(USE_W-SLOT_W){1'b0}}, slot_reg} < N_U);

    // row of cells: each holds one splitter and the bucket pair below it
    for (genvar i = 0; i < MAX_SPLITTERS; i++)
    begin : g_cell
        logic [KEY_W-1:0] left;
        if (i == 0)
        begin : g_first
            assign left = '0;
        end
        else
        begin : g_rest
            assign left = split_vec[i-1];
        end

        always_comb
        begin
            ctl_vec[i].wr       = (state_reg == ST_EVAL) && (kind_reg == KIND_LOAD)
                                  && (slot_reg == SLOT_W'(i));
            ctl_vec[i].clr      = (state_reg == ST_EVAL) && (kind_reg == KIND_CLEAR);
            ctl_vec[i].inc_even = (state_reg == ST_COUNT) && (pair == USE_W'(i))
                                  && !bucket_reg[0];
            ctl_vec[i].inc_odd  = (state_reg == ST_COUNT) && (pair == USE_W'(i))
                                  && bucket_reg[0];
        end

        sbc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .key        (key_reg),
            .left_split (left),
            .ctl        (ctl_vec[i]),
            .split      (split_vec[i]),
            .stat       (stat_vec[i]),
            .cnt_even   (even_vec[i]),
            .cnt_odd    (odd_vec[i])
        );
    end

    // top bucket (key above all splitters with the full table in use) lives outside the row
    always_comb
    begin
        tail_next = tail_reg;
        if ((state_reg == ST_EVAL) && (kind_reg == KIND_CLEAR))
        begin
            tail_next = '0;
        end
        else if ((state_reg == ST_COUNT) && (pair == N_U))
        begin
            tail_next = sat_inc(tail_reg);
        end
    end

    always_comb
    begin
        if (pair == N_U)
        begin
            sel_count = tail_reg;
        end
        else if (bucket_reg[0])
        begin
            sel_count = odd_vec[pair[SLOT_W-1:0]];
        end
        else
        begin
            sel_count = even_vec[pair[SLOT_W-1:0]];
        end
    end

    // sequencer: one binary search step per cycle over the cells' compare bits
    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        bucket_next = bucket_reg;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                lo_next    = '0;
                hi_next    = limit;
                state_next = (kind_reg == KIND_CLASSIFY) ? ST_SEARCH : ST_DONE;
            end
            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    if (stat_vec[mid[SLOT_W-1:0]].le)
                    begin
                        hi_next = mid;
                    end
                    else
                    begin
                        lo_next = mid + 1'b1;
                    end
                end
                else
                begin
                    // odd bucket when the splitter found equals the key
                    bucket_next = {lo_reg,
                                   (lo_reg < limit) && stat_vec[lo_reg[SLOT_W-1:0]].eq};
                    state_next  = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold here until the output register frees
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // response fields; unused fields read zero
    always_comb
    begin
        bucket_data = '0;
        count_data  = '0;
        pfx_data    = '0;
        unique case (kind_reg)
            KIND_LOAD:
            begin
                if (slot_ok && (slot_reg != '0))
                begin
                    pfx_data = stat_vec[slot_reg].pfx;
                end
            end
            KIND_CLASSIFY:
            begin
                bucket_data = bucket_reg;
                count_data  = sel_count;
            end
            default:
            begin
                bucket_data = '0;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_use_reg    <= N_U;
            out_valid_reg <= 1'b0;
            tail_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            tail_reg      <= tail_next;
            if (cfg_wr_en)
            begin
                in_use_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            slot_reg <= slot;
            key_reg  <= key;
        end
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        bucket_reg <= bucket_next;
        if (out_load)
        begin
            bucket_out_reg <= bucket_data;
            count_out_reg  <= count_data;
            pfx_out_reg    <= pfx_data;
        end
    end

    assign out_valid           = out_valid_reg;
    assign bucket              = bucket_out_reg;
    assign bucket_count        = count_out_reg;
    assign common_prefix_bytes = pfx_out_reg;

    // a request in flight blocks the next one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("request taken while another is in flight");

    // search window stays ordered and inside the table
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (lo_reg <= hi_reg) && (hi_reg <= N_U))
        else $error("search window out of order");

    // a classified key always leaves a nonzero count behind
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && (kind_reg == KIND_CLASSIFY)) |-> (sel_count != '0))
        else $error("classified bucket count is zero");

endmodule

FILE: tb/sv/tb_splitter_bucket_classifier_core.sv
`timescale 1ns / 100ps

module tb_splitter_bucket_classifier_core;

    import sbc_pkg::*;

    localparam int TABLE_DEPTH   = 32;
    localparam int BUCKET_SLOTS  = 2 * TABLE_DEPTH + 1;
    localparam int LIMIT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_W        = $clog2(TABLE_DEPTH);
    localparam int BUCKET_W      = $clog2(2 * TABLE_DEPTH + 2);
    localparam int ITEM_TARGET   = 1730;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 600000;
    localparam time HALF_PERIOD  = 10;

    // kind code the block has no operation for
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
    } request_t;

    typedef struct {
        logic [BUCKET_W-1:0] bucket;
        logic [CNT_W-1:0]    bucket_count;
        logic [PFX_W-1:0]    common_prefix_bytes;
    } response_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0]  cfg_wr_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [KIND_W-1:0]   kind = '0;
    logic [SLOT_W-1:0]   slot = '0;
    logic [KEY_W-1:0]    key = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [BUCKET_W-1:0] bucket;
    logic [CNT_W-1:0]    bucket_count;
    logic [PFX_W-1:0]    common_prefix_bytes;

    // requests waiting to be driven, and responses the block still owes
    request_t  pending_reqs[$];
    response_t owed_responses[$];

    // shadow of the block: splitters, histogram and the search limit
    logic [KEY_W-1:0] shadow_splitters[TABLE_DEPTH];
    logic [CNT_W-1:0] shadow_histogram[BUCKET_SLOTS];
    int               shadow_limit;

    // what the stimulus side believes the table holds, to aim keys at it
    logic [KEY_W-1:0] aimed_splitters[TABLE_DEPTH];

    int error_count  = 0;
    int cycle_count  = 0;
    int queued_total = 0;

    // sender burst shaping
    int burst_left;
    int gap_left;

    // receiver stall shaping
    int          stall_mode;
    int          mode_cycles;
    logic [15:0] ready_pattern;

    splitter_bucket_classifier_core #(
        .MAX_SPLITTERS(TABLE_DEPTH)
    ) DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .kind                (kind),
        .slot                (slot),
        .key                 (key),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .bucket              (bucket),
        .bucket_count        (bucket_count),
        .common_prefix_bytes (common_prefix_bytes)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Mask that keeps the top n bytes of a key.
    function automatic logic [KEY_W-1:0] top_bytes_mask(input int n);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int i = 0; i < n; i++)
        begin
            m[KEY_W-1-BYTE_W*i -: BYTE_W] = '1;
        end
        return m;
    endfunction

    // Apply one request to the shadow state and work out the response.
    function automatic response_t classify_and_count(input request_t r);
        response_t        resp;
        logic [KEY_W-1:0] diff;
        int               same;
        int               lo;
        int               hi;
        int               mid;
        int               pick;
        resp = '{default: '0};
        case (r.kind)
            KIND_LOAD:
            begin
                shadow_splitters[r.slot] = r.key;
                // slot zero has no neighbor below: prefix stays zero
                if (r.slot != 0)
                begin
                    diff = shadow_splitters[r.slot - 1] ^ r.key;
                    same = 0;
                    while (same < KEY_BYTES && diff[KEY_W-1-BYTE_W*same -: BYTE_W] == '0)
                    begin
                        same++;
                    end
                    resp.common_prefix_bytes = same[PFX_W-1:0];
                end
            end
            KIND_CLASSIFY:
            begin
                // lower bound over the slots in use; same steps on an unsorted table
                lo = 0;
                hi = shadow_limit;
                while (lo < hi)
                begin
                    mid = (lo + hi) / 2;
                    if (r.key <= shadow_splitters[mid])
                        hi = mid;
                    else
                        lo = mid + 1;
                end
                pick = 2 * lo;
                if (lo < shadow_limit && shadow_splitters[lo] == r.key)
                    pick++;
                // saturate the count at all ones
                if (shadow_histogram[pick] != '1)
                    shadow_histogram[pick]++;
                resp.bucket       = pick[BUCKET_W-1:0];
                resp.bucket_count = shadow_histogram[pick];
            end
            KIND_CLEAR:
            begin
                for (int i = 0; i < BUCKET_SLOTS; i++)
                begin
                    shadow_histogram[i] = '0;
                end
            end
            default:
            begin
                // unknown kind: no effect, all fields zero
            end
        endcase
        return resp;
    endfunction

    task automatic queue_request(
        input logic [KIND_W-1:0] k,
        input int                s,
        input logic [KEY_W-1:0]  v
    );
        request_t r;
        r.kind = k;
        r.slot = s[SLOT_W-1:0];
        r.key  = v;
        pending_reqs.push_back(r);
        if (k == KIND_LOAD)
            aimed_splitters[s] = v;
        queued_total++;
    endtask

    // Hold until nothing is queued, driven or owed, then let the block settle.
    task automatic wait_for_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || owed_responses.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write splitters_in_use; only called while the block is idle.
    task automatic set_splitter_limit(input int v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[LIMIT_W-1:0];
        shadow_limit = (v > TABLE_DEPTH) ? TABLE_DEPTH : v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Load every slot in ascending order with values that share prefixes.
    task automatic load_sorted_table();
        logic [KEY_W-1:0] vals[TABLE_DEPTH];
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] m;
        logic [KEY_W-1:0] t;
        int               j;
        base = {$urandom, $urandom};
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            m       = top_bytes_mask($urandom_range(0, KEY_BYTES));
            vals[i] = (base & m) | ({$urandom, $urandom} & ~m);
        end
        // insertion sort, ascending
        for (int i = 1; i < TABLE_DEPTH; i++)
        begin
            t = vals[i];
            j = i - 1;
            while (j >= 0 && vals[j] > t)
            begin
                vals[j + 1] = vals[j];
                j--;
            end
            vals[j + 1] = t;
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            queue_request(KIND_LOAD, i, vals[i]);
        end
    endtask

    // Mostly classify, with loads, clears and unknown kinds mixed in.
    task automatic queue_mixed_traffic(input int n);
        int               sel;
        int               idx;
        logic [KEY_W-1:0] v;
        logic [KEY_W-1:0] m;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            idx = $urandom_range(0, TABLE_DEPTH - 1);
            if (sel < 72)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: v = aimed_splitters[idx];
                    4:          v = aimed_splitters[idx] + 1;
                    5:          v = aimed_splitters[idx] - 1;
                    6:          v = '0;
                    7:          v = '1;
                    default:    v = {$urandom, $urandom};
                endcase
                queue_request(KIND_CLASSIFY, $urandom_range(0, TABLE_DEPTH - 1), v);
            end
            else if (sel < 90)
            begin
                // load near the slot below so prefixes of every length show up
                m = top_bytes_mask($urandom_range(0, KEY_BYTES));
                v = (aimed_splitters[(idx == 0) ? 0 : idx - 1] & m)
                    | ({$urandom, $urandom} & ~m);
                queue_request(KIND_LOAD, idx, v);
            end
            else if (sel < 95)
            begin
                queue_request(KIND_CLEAR, $urandom_range(0, TABLE_DEPTH - 1),
                              {$urandom, $urandom});
            end
            else
            begin
                queue_request(KIND_UNUSED, $urandom_range(0, TABLE_DEPTH - 1),
                              {$urandom, $urandom});
            end
        end
    endtask

    // Sender: present one request at a time from the pending queue, in bursts.
    always @(posedge clk or negedge rst_n)
    begin
        request_t acc;
        request_t nxt;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            kind       <= '0;
            slot       <= '0;
            key        <= '0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            // predict on the accepting edge, with the limit in force now
            if (in_valid && in_ready)
            begin
                acc.kind = kind;
                acc.slot = slot;
                acc.key  = key;
                owed_responses.push_back(classify_and_count(acc));
            end
            // hold the request until it is taken
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    nxt = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    kind     <= nxt.kind;
                    slot     <= nxt.slot;
                    key      <= nxt.key;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        // new burst; a quarter of them follow with no gap at all
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: take responses, compare each against the oldest owed one.
    always @(posedge clk or negedge rst_n)
    begin
        response_t want;
        if (!rst_n)
        begin
            out_ready     <= 1'b0;
            stall_mode    = 0;
            mode_cycles   = 0;
            ready_pattern = 16'hFFFF;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (owed_responses.size() == 0)
                begin
                    $error("response with no request waiting: bucket %0d count %0d prefix %0d",
                           bucket, bucket_count, common_prefix_bytes);
                    error_count++;
                end
                else
                begin
                    want = owed_responses.pop_front();
                    if (bucket !== want.bucket)
                    begin
                        $error("bucket: expected %0d, got %0d", want.bucket, bucket);
                        error_count++;
                    end
                    if (bucket_count !== want.bucket_count)
                    begin
                        $error("bucket_count: expected %0d, got %0d",
                               want.bucket_count, bucket_count);
                        error_count++;
                    end
                    if (common_prefix_bytes !== want.common_prefix_bytes)
                    begin
                        $error("common_prefix_bytes: expected %0d, got %0d",
                               want.common_prefix_bytes, common_prefix_bytes);
                        error_count++;
                    end
                end
            end
            // switch stall style each time mode_cycles runs out
            mode_cycles++;
            if (mode_cycles >= 64)
            begin
                mode_cycles   = 0;
                stall_mode    = $urandom_range(0, 3);
                ready_pattern = $urandom_range(0, 16'hFFFF) | 16'h0001;
            end
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                2:       out_ready <= (cycle_count % 9 == 0);
                default: out_ready <= ready_pattern[cycle_count % 16];
            endcase
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            shadow_splitters[i] = '0;
            aimed_splitters[i]  = '0;
        end
        for (int i = 0; i < BUCKET_SLOTS; i++)
        begin
            shadow_histogram[i] = '0;
        end
        shadow_limit = TABLE_DEPTH;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: four splitters in use, loaded in order from slot zero, then reloaded out of order.
        set_splitter_limit(4);
        queue_request(KIND_LOAD, 0, 64'h1000_0000_0000_0000);     // slot zero
        queue_request(KIND_LOAD, 1, 64'h1000_0000_0000_0000);     // identical splitter
        queue_request(KIND_LOAD, 2, 64'h1000_0000_00AB_0000);     // partial prefix
        queue_request(KIND_LOAD, 3, 64'hFFFF_FFFF_FFFF_FF00);
        queue_request(KIND_CLASSIFY, 0, 64'h0);                    // below all
        queue_request(KIND_CLASSIFY, 0, 64'h1000_0000_0000_0000);  // equal, first of twins
        queue_request(KIND_CLASSIFY, 0, 64'h1000_0000_0000_0001);  // between
        queue_request(KIND_CLASSIFY, 0, 64'h1000_0000_00AB_0000);
        queue_request(KIND_CLASSIFY, 0, 64'hFFFF_FFFF_FFFF_FF00);  // equal, last
        queue_request(KIND_CLASSIFY, 0, 64'hFFFF_FFFF_FFFF_FFFF);  // above all
        queue_request(KIND_CLASSIFY, 0, 64'h0);                    // count grows
        queue_request(KIND_CLEAR, 0, 64'h0);
        queue_request(KIND_CLASSIFY, 0, 64'h0);                    // count restarts
        queue_request(KIND_UNUSED, TABLE_DEPTH - 1, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_request(KIND_UNUSED, 0, 64'h0);
        queue_request(KIND_LOAD, 4, 64'h0000_0000_0000_0005);     // out of order
        queue_request(KIND_LOAD, 2, 64'h0FFF_FFFF_FFFF_FFFF);     // below slot 1
        queue_request(KIND_CLASSIFY, 0, 64'h1000_0000_0000_0002);  // unsorted search
        queue_request(KIND_LOAD, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_request(KIND_CLASSIFY, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        wait_for_idle();

        // Register zero: nothing searched, everything lands in bucket 0.
        set_splitter_limit(0);
        queue_request(KIND_CLASSIFY, 0, 64'h0);
        queue_request(KIND_CLASSIFY, TABLE_DEPTH - 1, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_request(KIND_CLASSIFY, 0, {$urandom, $urandom});
        wait_for_idle();

        // One splitter in use, then fill the whole table in order.
        set_splitter_limit(1);
        queue_request(KIND_CLASSIFY, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_request(KIND_CLASSIFY, 0, 64'h0);
        load_sorted_table();
        wait_for_idle();

        // Random phases: pick a limit, maybe reload sorted, then mixed traffic.
        while (queued_total < ITEM_TARGET)
        begin
            case ($urandom_range(0, 7))
                0:       set_splitter_limit(0);
                1:       set_splitter_limit(1);
                2, 3:    set_splitter_limit(TABLE_DEPTH);
                4:       set_splitter_limit($urandom_range(TABLE_DEPTH + 1, 63));
                default: set_splitter_limit($urandom_range(1, TABLE_DEPTH));
            endcase
            if ($urandom_range(0, 3) == 0)
                load_sorted_table();
            queue_mixed_traffic($urandom_range(40, 160));
            wait_for_idle();
        end

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/sbc_pkg.sv
rtl/core/sbc_cell.sv
rtl/core/splitter_bucket_classifier_core.sv
tb/sv/tb_splitter_bucket_classifier_core.sv
